@@ hdl/tcs_pkg.sv @@
package tcs_pkg;

    // Default screen geometry
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;

    // Field widths of one beat
    localparam int CHAR_W     = 8;
    localparam int REQ_ROW_W  = 5;
    localparam int REQ_COL_W  = 7;

    // Command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Control characters and fill values
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    // Operation codes on the op field
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Command class decided by the front
    typedef enum logic [2:0] {
        K_READ,
        K_TAB,
        K_BS,
        K_CR,
        K_LF,
        K_PRINT
    } t_kind;

    // One queued command
    typedef struct packed {
        t_kind                 kind;
        logic [CHAR_W-1:0]     ch;
        logic [REQ_ROW_W-1:0]  row;
        logic [REQ_COL_W-1:0]  col;
    } t_cmd;

    // Back end sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_BLANK
    } t_state;

endpackage

@@ hdl/tcs_front.sv @@
module tcs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [tcs_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcs_pkg::REQ_ROW_W-1:0]  i_read_row,
    input  logic [tcs_pkg::REQ_COL_W-1:0]  i_read_col,
    output logic                           o_cmd_valid,
    output tcs_pkg::t_cmd                  o_cmd,
    input  logic                           i_cmd_pop
);

    localparam int QD   = tcs_pkg::QUEUE_DEPTH;
    localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;

    tcs_pkg::t_cmd    r_q [QD];
    logic [QP_W-1:0]  r_wp;
    logic [QP_W-1:0]  r_rp;
    logic [QP_W:0]    r_count;
    logic [QP_W-1:0]  n_wp;
    logic [QP_W-1:0]  n_rp;
    logic [QP_W:0]    n_count;
    logic             push;
    logic             pop;
    logic             full;
    tcs_pkg::t_kind   kind;
    tcs_pkg::t_cmd    cmd_in;

    // Classify the incoming beat
    always_comb begin
        if (i_op == tcs_pkg::OP_READ) begin
            kind = tcs_pkg::K_READ;
        end else begin
            case (i_char_code)
                tcs_pkg::CHAR_TAB: kind = tcs_pkg::K_TAB;
                tcs_pkg::CHAR_BS:  kind = tcs_pkg::K_BS;
                tcs_pkg::CHAR_CR:  kind = tcs_pkg::K_CR;
                tcs_pkg::CHAR_LF:  kind = tcs_pkg::K_LF;
                default:           kind = tcs_pkg::K_PRINT;
            endcase
        end
        cmd_in.kind = kind;
        cmd_in.ch   = i_char_code;
        cmd_in.row  = i_read_row;
        cmd_in.col  = i_read_col;
    end

    // Queue control
    assign full        = (r_count == (QP_W+1)'(QD));
    assign busy        = full;
    assign push        = start && !full;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp    = push ? r_wp + 1'b1 : r_wp;
        n_rp    = pop ? r_rp + 1'b1 : r_rp;
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QP_W+1)'(QD))
        else $error("command queue count beyond depth");

endmodule

@@ hdl/tcs_back.sv @@
module tcs_back #(
    parameter int SCREEN_COLUMNS = tcs_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcs_pkg::SCREEN_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  tcs_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    output logic                           o_strobe,
    output logic [tcs_pkg::REQ_COL_W-1:0]  o_cursor_col,
    output logic [tcs_pkg::REQ_ROW_W-1:0]  o_cursor_row,
    output logic                           o_scrolled,
    output logic [tcs_pkg::CHAR_W-1:0]     o_cell_char
);

    localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int CW1    = COL_W + 1;
    localparam int RW1    = ROW_W + 1;

    // Screen memory, rows kept as a ring starting at r_top
    logic [tcs_pkg::CHAR_W-1:0] r_mem [CELLS];
    logic [tcs_pkg::CHAR_W-1:0] r_rdata;

    tcs_pkg::t_state            r_state, n_state;
    logic [COL_W-1:0]           r_col, n_col;
    logic [ROW_W-1:0]           r_row, n_row;
    logic [ROW_W-1:0]           r_top, n_top;
    logic [ADDR_W-1:0]          r_sweep, n_sweep;
    logic [ADDR_W-1:0]          r_sweep_last, n_sweep_last;
    logic                       r_rd_ok, n_rd_ok;
    logic                       r_strobe, n_strobe;
    logic                       r_scrolled, n_scrolled;
    logic [tcs_pkg::CHAR_W-1:0] r_cell, n_cell;

    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic [tcs_pkg::CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0]          raddr;
    logic                       req_ok;
    logic [ROW_W-1:0]           req_row;
    logic [COL_W-1:0]           req_col;
    logic [ADDR_W-1:0]          req_addr;
    logic [ADDR_W-1:0]          cur_addr;
    logic [ADDR_W-1:0]          top_base;
    logic [ROW_W-1:0]           top_inc;
    logic [CW1-1:0]             c;
    logic [ROW_W-1:0]           rr;
    logic                       nl;

    // Logical row to ring position
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] l,
                                                  input logic [ROW_W-1:0] top);
        logic [RW1-1:0] sum;
        sum = {1'b0, l} + {1'b0, top};
        if (sum >= RW1'(SCREEN_ROWS)) begin
            sum = sum - RW1'(SCREEN_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
    endfunction

    // Address arithmetic
    assign req_ok   = (int'(i_cmd.row) < SCREEN_ROWS) && (int'(i_cmd.col) < SCREEN_COLUMNS);
    assign req_row  = ROW_W'(i_cmd.row);
    assign req_col  = COL_W'(i_cmd.col);
    assign req_addr = cell_addr(phys_row(req_row, r_top), req_col);
    assign raddr    = req_ok ? req_addr : '0;
    assign cur_addr = cell_addr(phys_row(r_row, r_top), r_col);
    assign top_base = cell_addr(r_top, '0);
    assign top_inc  = (r_top == ROW_W'(SCREEN_ROWS - 1)) ? '0 : r_top + 1'b1;

    // Sequencer: next state and memory write port
    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_top        = r_top;
        n_sweep      = r_sweep;
        n_sweep_last = r_sweep_last;
        n_rd_ok      = r_rd_ok;
        n_strobe     = 1'b0;
        n_scrolled   = r_scrolled;
        n_cell       = r_cell;
        o_cmd_pop    = 1'b0;
        we           = 1'b0;
        waddr        = r_sweep;
        wdata        = tcs_pkg::CHAR_NUL;
        c            = {1'b0, r_col};
        rr           = r_row;
        nl           = 1'b0;
        case (r_state)
            tcs_pkg::ST_CLEAR: begin
                we = 1'b1;
                if (r_sweep == r_sweep_last) begin
                    n_state = tcs_pkg::ST_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            tcs_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == tcs_pkg::K_READ) begin
                        n_rd_ok = req_ok;
                        n_state = tcs_pkg::ST_READ;
                    end else begin
                        case (i_cmd.kind)
                            tcs_pkg::K_TAB: begin
                                c = ({1'b0, r_col} | CW1'(3)) + CW1'(1);
                            end
                            tcs_pkg::K_BS: begin
                                if (r_col != '0) begin
                                    c = {1'b0, r_col} - CW1'(1);
                                end else if (r_row != '0) begin
                                    rr = r_row - 1'b1;
                                    c  = CW1'(SCREEN_COLUMNS - 1);
                                end
                            end
                            tcs_pkg::K_CR: begin
                                c = '0;
                            end
                            tcs_pkg::K_LF: begin
                                nl = 1'b1;
                            end
                            tcs_pkg::K_PRINT: begin
                                we    = 1'b1;
                                waddr = cur_addr;
                                wdata = i_cmd.ch;
                                c     = {1'b0, r_col} + CW1'(1);
                            end
                            default: ;
                        endcase
                        // Wrap past the last column
                        if (c >= CW1'(SCREEN_COLUMNS)) begin
                            nl = 1'b1;
                        end
                        n_strobe   = 1'b1;
                        n_scrolled = 1'b0;
                        n_cell     = tcs_pkg::CHAR_NUL;
                        if (nl) begin
                            c = '0;
                            if (rr == ROW_W'(SCREEN_ROWS - 1)) begin
                                // Scroll: old top row becomes the blank bottom row
                                n_top        = top_inc;
                                n_sweep      = top_base;
                                n_sweep_last = top_base + ADDR_W'(SCREEN_COLUMNS - 1);
                                n_state      = tcs_pkg::ST_BLANK;
                                n_strobe     = 1'b0;
                            end else begin
                                rr = rr + 1'b1;
                            end
                        end
                        n_col = c[COL_W-1:0];
                        n_row = rr;
                    end
                end
            end
            tcs_pkg::ST_READ: begin
                n_strobe   = 1'b1;
                n_scrolled = 1'b0;
                n_cell     = r_rd_ok ? r_rdata : tcs_pkg::CHAR_NUL;
                n_state    = tcs_pkg::ST_IDLE;
            end
            tcs_pkg::ST_BLANK: begin
                we    = 1'b1;
                wdata = tcs_pkg::CHAR_BLANK;
                if (r_sweep == r_sweep_last) begin
                    n_strobe   = 1'b1;
                    n_scrolled = 1'b1;
                    n_state    = tcs_pkg::ST_IDLE;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            default: begin
                n_state = tcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcs_pkg::ST_CLEAR;
            r_col        <= '0;
            r_row        <= '0;
            r_top        <= '0;
            r_sweep      <= '0;
            r_sweep_last <= ADDR_W'(CELLS - 1);
            r_rd_ok      <= 1'b0;
            r_strobe     <= 1'b0;
            r_scrolled   <= 1'b0;
            r_cell       <= '0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_top        <= n_top;
            r_sweep      <= n_sweep;
            r_sweep_last <= n_sweep_last;
            r_rd_ok      <= n_rd_ok;
            r_strobe     <= n_strobe;
            r_scrolled   <= n_scrolled;
            r_cell       <= n_cell;
        end
    end

    // Screen memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // Result ports
    assign o_strobe     = r_strobe;
    assign o_cursor_col = tcs_pkg::REQ_COL_W'(r_col);
    assign o_cursor_row = tcs_pkg::REQ_ROW_W'(r_row);
    assign o_scrolled   = r_scrolled;
    assign o_cell_char  = r_cell;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < CW1'(SCREEN_COLUMNS)) && ({1'b0, r_row} < RW1'(SCREEN_ROWS)))
        else $error("cursor outside the screen");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_scrolled) |->
            (r_row == ROW_W'(SCREEN_ROWS - 1)) && (r_col == '0))
        else $error("scroll result with cursor off the bottom-left");

    a_blank_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcs_pkg::ST_BLANK && r_sweep == r_sweep_last) |=>
            (r_strobe && r_scrolled && r_state == tcs_pkg::ST_IDLE))
        else $error("row blanking ended without a scroll result");

    a_top_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_top != $past(r_top)) |-> (r_state == tcs_pkg::ST_BLANK))
        else $error("ring top moved outside a scroll");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == tcs_pkg::ST_IDLE) && !we || o_cmd_pop &&
            (i_cmd.kind == tcs_pkg::K_PRINT))
        else $error("command taken while the sequencer is busy");

endmodule

@@ hdl/text_terminal_cursor_scroll.sv @@
// Character-cell text terminal. Drive start with a beat (i_op 0 puts i_char_code at the cursor,
// or moves the cursor for TAB, BS, CR and LF; i_op 1 reads the cell at i_read_row/i_read_col);
// it is taken when busy is low. Every beat yields exactly one result, shown for a single cycle
// with o_strobe high; the receiver cannot stall it, so sample o_strobe every cycle. A two-entry
// command queue sits in front of the sequencer, so busy only rises when both entries are
// waiting. At the sequencer a read goes through one registered memory read, and a put that
// scrolls waits while the old top row of the row ring is refilled with spaces. After reset
// the sequencer clears all SCREEN_ROWS * SCREEN_COLUMNS cells of the screen memory; beats are
// still queued during that pass, but results appear only after it ends.
module text_terminal_cursor_scroll #(
    parameter int SCREEN_COLUMNS = tcs_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcs_pkg::SCREEN_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [tcs_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcs_pkg::REQ_ROW_W-1:0]  i_read_row,
    input  logic [tcs_pkg::REQ_COL_W-1:0]  i_read_col,
    output logic                           o_strobe,
    output logic [tcs_pkg::REQ_COL_W-1:0]  o_cursor_col,
    output logic [tcs_pkg::REQ_ROW_W-1:0]  o_cursor_row,
    output logic                           o_scrolled,
    output logic [tcs_pkg::CHAR_W-1:0]     o_cell_char
);

    logic           cmd_valid;
    logic           cmd_pop;
    tcs_pkg::t_cmd  cmd;

    // Front: classify and queue
    tcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back: cursor, screen memory, scroll
    tcs_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_strobe     (o_strobe),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_scrolled   (o_scrolled),
        .o_cell_char  (o_cell_char)
    );

endmodule
